// ----- rtl/dct8x8_quantizer_macros.svh -----
// ----------------------------------------------------------------------------
// dct8x8_quantizer_macros.svh
// Assertion macros used by the quantizer RTL (dq_fifo).
// ----------------------------------------------------------------------------
`ifndef DCT8X8_QUANTIZER_MACROS_SVH
`define DCT8X8_QUANTIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Types, constants and tables of the 8x8 DCT quantizer.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int BLOCK_DIM         = 8;
   localparam int BLOCK_ITEMS       = BLOCK_DIM * BLOCK_DIM;
   localparam int IDX_W             = 6;
   localparam int SAMPLE_W          = 8;
   localparam int COEF_W            = 11;
   localparam int QUAL_W            = 7;
   localparam int DEF_COS_FRAC_BITS = 14;
   localparam int COS_W_MAX         = 17;
   localparam int COEF_POS_MAX      = 1023;
   localparam int COEF_NEG_MAG      = 1024;
   localparam int FIFO_DEPTH        = 4;
   localparam int FIFO_PTR_W        = 2;
   localparam int FIFO_CNT_W        = 3;
   localparam int SCALE_W           = 13;
   localparam int TAB_W             = 7;

   localparam logic [QUAL_W-1:0] DEF_QUALITY = 7'd50;

   // Row per precision 10..16: A(0)/2, then cos(j*pi/16)/2 for j = 1..7, then 0.
   localparam logic [15:0] HALF_COS [7][9] = '{
      '{16'd362,   16'd502,   16'd473,   16'd426,   16'd362,   16'd284,   16'd196,
        16'd100,   16'd0},
      '{16'd724,   16'd1004,  16'd946,   16'd851,   16'd724,   16'd569,   16'd392,
        16'd200,   16'd0},
      '{16'd1448,  16'd2009,  16'd1892,  16'd1703,  16'd1448,  16'd1138,  16'd784,
        16'd400,   16'd0},
      '{16'd2896,  16'd4017,  16'd3784,  16'd3406,  16'd2896,  16'd2276,  16'd1567,
        16'd799,   16'd0},
      '{16'd5793,  16'd8035,  16'd7568,  16'd6811,  16'd5793,  16'd4551,  16'd3135,
        16'd1598,  16'd0},
      '{16'd11585, 16'd16069, 16'd15137, 16'd13623, 16'd11585, 16'd9102,  16'd6270,
        16'd3196,  16'd0},
      '{16'd23170, 16'd32138, 16'd30274, 16'd27246, 16'd23170, 16'd18205, 16'd12540,
        16'd6393,  16'd0}
   };

   localparam logic [TAB_W-1:0] LUM_TAB [BLOCK_ITEMS] = '{
      7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
      7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
      7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
      7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
      7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
      7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
      7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
      7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
   };

   localparam logic [TAB_W-1:0] CHR_TAB [BLOCK_ITEMS] = '{
      7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
      7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
   };

   // 5000 / q for q = 1..49; entry 0 is never used.
   localparam logic [SCALE_W-1:0] SCALE_TAB [50] = '{
      13'd0,
      13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833, 13'd714, 13'd625,
      13'd555,  13'd500,  13'd454,  13'd416,  13'd384,  13'd357, 13'd333, 13'd312,
      13'd294,  13'd277,  13'd263,  13'd250,  13'd238,  13'd227, 13'd217, 13'd208,
      13'd200,  13'd192,  13'd185,  13'd178,  13'd172,  13'd166, 13'd161, 13'd156,
      13'd151,  13'd147,  13'd142,  13'd138,  13'd135,  13'd131, 13'd128, 13'd125,
      13'd121,  13'd119,  13'd116,  13'd113,  13'd111,  13'd108, 13'd106, 13'd104,
      13'd102
   };

   typedef struct packed {
      logic full;
   } dq_front_stat_type;

   typedef struct packed {
      logic             done_blk;
      logic [IDX_W-1:0] rd_addr;
   } dq_rd_req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] y;
      logic signed [COEF_W-1:0] cb;
      logic signed [COEF_W-1:0] cr;
      logic [IDX_W-1:0]         idx;
      logic                     last;
   } dq_result_type;

   function automatic int clamp_fb(input int fb);
      int r;
      r = fb;
      if (r < 10) r = 10;
      if (r > 16) r = 16;
      return r;
   endfunction

   function automatic logic signed [COS_W_MAX-1:0] cos_coef(input logic [2:0] k,
                                                            input logic [2:0] n,
                                                            input int fb);
      int m;
      int row;
      logic neg;
      logic signed [COS_W_MAX-1:0] v;
      row = clamp_fb(fb) - 10;
      m   = ((2 * int'(n) + 1) * int'(k)) & 31;
      neg = 1'b0;
      if (m > 16) m = 32 - m;
      if (m > 8) begin
         m   = 16 - m;
         neg = 1'b1;
      end
      v = signed'({1'b0, HALF_COS[row][m]});
      return neg ? -v : v;
   endfunction

   // Scale factor for a quality setting; settings outside 1..100 act as 50.
   function automatic logic [SCALE_W-1:0] quality_scale(input logic [QUAL_W-1:0] q);
      logic [QUAL_W-1:0] qq;
      qq = q;
      if (q == '0 || q > 7'd100) qq = DEF_QUALITY;
      if (qq < DEF_QUALITY) return SCALE_TAB[qq[5:0]];
      return SCALE_W'(9'd200 - {1'b0, qq, 1'b0});
   endfunction

endpackage

// ----- rtl/dq_front.sv -----
// ----------------------------------------------------------------------------
// dq_front
// Collects one block of 64 sample words into the sample store.
// ----------------------------------------------------------------------------
module dq_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [dq_pkg::SAMPLE_W-1:0]     req_y_sample,
   input  logic signed [dq_pkg::SAMPLE_W-1:0]     req_cb_sample,
   input  logic signed [dq_pkg::SAMPLE_W-1:0]     req_cr_sample,
   input  dq_pkg::dq_rd_req_type                  rd_req,
   output dq_pkg::dq_front_stat_type              stat,
   output logic [3*dq_pkg::SAMPLE_W-1:0]          sample_rd
);

   logic [3*dq_pkg::SAMPLE_W-1:0] store_mem [dq_pkg::BLOCK_ITEMS];
   logic [dq_pkg::IDX_W-1:0]      count_ff;
   logic [dq_pkg::IDX_W-1:0]      count_in;
   logic                          full_ff;
   logic                          full_in;
   logic                          accept;
   logic [3*dq_pkg::SAMPLE_W-1:0] sample_rd_ff;

   assign accept    = req_valid && !full_ff;
   assign req_stall = full_ff;
   assign stat.full = full_ff;
   assign sample_rd = sample_rd_ff;

   always_comb begin
      count_in = count_ff;
      full_in  = full_ff;
      if (accept) begin
         count_in = count_ff + 1'b1;
         if (count_ff == dq_pkg::IDX_W'(dq_pkg::BLOCK_ITEMS - 1)) full_in = 1'b1;
      end
      if (rd_req.done_blk) full_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_mem[count_ff] <= {req_cr_sample, req_cb_sample, req_y_sample};
      end
      sample_rd_ff <= store_mem[rd_req.rd_addr];
   end

endmodule

// ----- rtl/dq_engine.sv -----
// ----------------------------------------------------------------------------
// dq_engine
// Separable DCT on three multiply-accumulate lanes, then quantization by a
// bit-serial divider per channel.
// ----------------------------------------------------------------------------
module dq_engine #(
   parameter int COS_FRAC_BITS = dq_pkg::DEF_COS_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dq_pkg::dq_front_stat_type          front_stat,
   input  logic [3*dq_pkg::SAMPLE_W-1:0]      sample_rd,
   input  logic [dq_pkg::QUAL_W-1:0]          quality,
   input  logic                               queue_full,
   output dq_pkg::dq_rd_req_type              rd_req,
   output logic                               res_push,
   output dq_pkg::dq_result_type              res
);

   localparam int FB  = dq_pkg::clamp_fb(COS_FRAC_BITS);
   localparam int CW  = FB + 1;
   localparam int HW  = FB + 12;
   localparam int AW  = 2 * FB + 13;
   localparam int PW  = HW + CW;
   localparam int NW  = 2 * FB + 26;
   localparam int QW  = 12;
   localparam int SW  = 20;
   localparam int EW  = 14;
   localparam int RCP = 41943;

   typedef enum logic [3:0] {
      S_IDLE, S_HPASS, S_HDRAIN, S_VPASS, S_VDRAIN,
      S_QRD, S_QD1, S_QD2, S_QD3, S_QDIV, S_QOUT
   } state_type;

   state_type                   state_ff;
   logic [8:0]                  cnt_ff;
   logic [dq_pkg::IDX_W-1:0]    qidx_ff;
   logic [3:0]                  step_ff;

   logic [2:0]                  c_out;
   logic [2:0]                  c_mid;
   logic [2:0]                  c_in;
   logic                        issue;
   logic                        vpass;
   logic                        drained;
   logic [dq_pkg::IDX_W-1:0]    tmp_raddr;
   logic [2:0]                  coef_k;

   logic [3*HW-1:0]             tmp_mem [dq_pkg::BLOCK_ITEMS];
   logic [3*AW-1:0]             fmem    [dq_pkg::BLOCK_ITEMS];
   logic [3*HW-1:0]             tmp_rd_ff;
   logic [3*AW-1:0]             fm_rd_ff;

   logic                        s1_vld_ff;
   logic                        s1_first_ff;
   logic                        s1_last_ff;
   logic                        s1_v_ff;
   logic [dq_pkg::IDX_W-1:0]    s1_waddr_ff;
   logic signed [CW-1:0]        coef_ff;
   logic                        s2_vld_ff;
   logic                        s2_first_ff;
   logic                        s2_last_ff;
   logic                        s2_v_ff;
   logic [dq_pkg::IDX_W-1:0]    s2_waddr_ff;
   logic signed [HW-1:0]        opnd [3];
   logic signed [PW-1:0]        pf [3];
   logic signed [AW-1:0]        prod_ff [3];
   logic signed [AW-1:0]        acc_ff [3];
   logic signed [AW-1:0]        acc_in [3];

   logic [dq_pkg::SCALE_W-1:0]  scale;
   logic [SW-1:0]               sp_ff [2];
   logic [EW-1:0]               qe_ff [2];
   logic [dq_pkg::SCALE_W-1:0]  div_ff [2];
   logic [SW+15:0]              rp [2];
   logic [SW-1:0]               rem [2];
   logic [EW-1:0]               dv [2];
   logic                        neg_ff [3];
   logic [AW-1:0]               mag_ff [3];
   logic [NW-1:0]               num_ff [3];
   logic [NW-1:0]               den_ff [3];
   logic [QW-1:0]               quo_ff [3];

   assign c_out   = cnt_ff[8:6];
   assign c_mid   = cnt_ff[5:3];
   assign c_in    = cnt_ff[2:0];
   assign issue   = (state_ff == S_HPASS) || (state_ff == S_VPASS);
   assign vpass   = (state_ff == S_VPASS);
   assign drained = !s1_vld_ff && !s2_vld_ff;
   assign tmp_raddr = {c_in, c_mid};
   assign coef_k    = vpass ? c_out : c_mid;

   assign rd_req.rd_addr  = {c_out, c_in};
   assign rd_req.done_blk = (state_ff == S_HDRAIN) && drained;

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         qidx_ff  <= '0;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (front_stat.full) state_ff <= S_HPASS;
            end
            S_HPASS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) state_ff <= S_HDRAIN;
            end
            S_HDRAIN: begin
               if (drained) state_ff <= S_VPASS;
            end
            S_VPASS: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == '1) state_ff <= S_VDRAIN;
            end
            S_VDRAIN: begin
               qidx_ff <= '0;
               if (drained) state_ff <= S_QRD;
            end
            S_QRD:  state_ff <= S_QD1;
            S_QD1:  state_ff <= S_QD2;
            S_QD2:  state_ff <= S_QD3;
            S_QD3: begin
               step_ff  <= '0;
               state_ff <= S_QDIV;
            end
            S_QDIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'(QW - 1)) state_ff <= S_QOUT;
            end
            S_QOUT: begin
               if (!queue_full) begin
                  qidx_ff <= qidx_ff + 1'b1;
                  if (qidx_ff == dq_pkg::IDX_W'(dq_pkg::BLOCK_ITEMS - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_QRD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Multiply-accumulate pipeline: operand fetch, multiply, accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (s1_v_ff) begin
            opnd[c] = signed'(tmp_rd_ff[c*HW +: HW]);
         end else begin
            opnd[c] = {{(HW-dq_pkg::SAMPLE_W){sample_rd[c*dq_pkg::SAMPLE_W+7]}},
                       sample_rd[c*dq_pkg::SAMPLE_W +: dq_pkg::SAMPLE_W]};
         end
         pf[c]     = PW'(opnd[c]) * PW'(coef_ff);
         acc_in[c] = s2_first_ff ? prod_ff[c] : acc_ff[c] + prod_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (c_in == 3'd0);
      s1_last_ff  <= (c_in == 3'd7);
      s1_v_ff     <= vpass;
      s1_waddr_ff <= {c_out, c_mid};
      coef_ff     <= CW'(dq_pkg::cos_coef(coef_k, c_in, FB));
      tmp_rd_ff   <= tmp_mem[tmp_raddr];
      fm_rd_ff    <= fmem[qidx_ff];
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_v_ff     <= s1_v_ff;
      s2_waddr_ff <= s1_waddr_ff;
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= AW'(pf[c]);
         if (s2_vld_ff) acc_ff[c] <= acc_in[c];
      end
      if (s2_vld_ff && s2_last_ff) begin
         if (s2_v_ff) begin
            fmem[s2_waddr_ff] <= {acc_in[2], acc_in[1], acc_in[0]};
         end else begin
            tmp_mem[s2_waddr_ff] <= {HW'(acc_in[2]), HW'(acc_in[1]), HW'(acc_in[0])};
         end
      end
   end

   // Divisor = (scale * table + 50) / 100, by reciprocal and one correction.
   assign scale = dq_pkg::quality_scale(quality);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rp[i]  = (SW+16)'(sp_ff[i]) * (SW+16)'(RCP);
         rem[i] = sp_ff[i] - SW'(qe_ff[i]) * SW'(100);
         dv[i]  = (rem[i] >= SW'(100)) ? qe_ff[i] + 1'b1 : qe_ff[i];
         if (dv[i] == '0) dv[i] = EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_QRD: begin
            sp_ff[0] <= SW'(scale) * SW'(dq_pkg::LUM_TAB[qidx_ff]) + SW'(50);
            sp_ff[1] <= SW'(scale) * SW'(dq_pkg::CHR_TAB[qidx_ff]) + SW'(50);
         end
         S_QD1: begin
            for (int i = 0; i < 2; i++) qe_ff[i] <= rp[i][SW+15:22];
            for (int c = 0; c < 3; c++) begin
               neg_ff[c] <= fm_rd_ff[c*AW+AW-1];
               mag_ff[c] <= fm_rd_ff[c*AW+AW-1] ? AW'(-fm_rd_ff[c*AW +: AW])
                                                 : fm_rd_ff[c*AW +: AW];
            end
         end
         S_QD2: begin
            for (int i = 0; i < 2; i++) div_ff[i] <= dq_pkg::SCALE_W'(dv[i]);
         end
         S_QD3: begin
            // Rounded quotient (2|x| + d) / (2d), d being the divisor at cosine scale.
            for (int c = 0; c < 3; c++) begin
               num_ff[c] <= (NW'(mag_ff[c]) << 1) + (NW'(div_ff[c == 0 ? 0 : 1]) << (2*FB));
               den_ff[c] <= NW'(div_ff[c == 0 ? 0 : 1]) << (2*FB + QW);
               quo_ff[c] <= '0;
            end
         end
         S_QDIV: begin
            for (int c = 0; c < 3; c++) begin
               if (num_ff[c] >= den_ff[c]) begin
                  num_ff[c] <= num_ff[c] - den_ff[c];
                  quo_ff[c] <= {quo_ff[c][QW-2:0], 1'b1};
               end else begin
                  quo_ff[c] <= {quo_ff[c][QW-2:0], 1'b0};
               end
               den_ff[c] <= den_ff[c] >> 1;
            end
         end
         default: begin
         end
      endcase
   end

   function automatic logic signed [dq_pkg::COEF_W-1:0] sat_coef(input logic [QW-1:0] r,
                                                                 input logic neg);
      logic [QW-1:0] m;
      if (neg) begin
         m = (r > QW'(dq_pkg::COEF_NEG_MAG)) ? QW'(dq_pkg::COEF_NEG_MAG) : r;
         m = QW'(0) - m;
      end else begin
         m = (r > QW'(dq_pkg::COEF_POS_MAX)) ? QW'(dq_pkg::COEF_POS_MAX) : r;
      end
      return signed'(m[dq_pkg::COEF_W-1:0]);
   endfunction

   assign res_push = (state_ff == S_QOUT) && !queue_full;
   assign res.y    = sat_coef(quo_ff[0], neg_ff[0]);
   assign res.cb   = sat_coef(quo_ff[1], neg_ff[1]);
   assign res.cr   = sat_coef(quo_ff[2], neg_ff[2]);
   assign res.idx  = qidx_ff;
   assign res.last = (qidx_ff == dq_pkg::IDX_W'(dq_pkg::BLOCK_ITEMS - 1));

endmodule

// ----- rtl/dq_fifo.sv -----
// ----------------------------------------------------------------------------
// dq_fifo
// Short result queue between the engine and the output channel.
// ----------------------------------------------------------------------------
`include "dct8x8_quantizer_macros.svh"

module dq_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dq_pkg::dq_result_type  push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dq_pkg::dq_result_type  head
);

   dq_pkg::dq_result_type               mem_ff [dq_pkg::FIFO_DEPTH];
   logic [dq_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff;
   logic [dq_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff;
   logic [dq_pkg::FIFO_CNT_W-1:0]       count_ff;
   logic                                pop;

   assign full      = (count_ff == dq_pkg::FIFO_CNT_W'(dq_pkg::FIFO_DEPTH));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   `DQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= dq_pkg::FIFO_CNT_W'(dq_pkg::FIFO_DEPTH), "queue count above depth")
   `DQ_ASSERT_NXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count missed a push")
   `DQ_ASSERT_NXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count missed a pop")

endmodule

// ----- rtl/dct8x8_quantizer.sv -----
// ----------------------------------------------------------------------------
// dct8x8_quantizer
// Forward 8x8 DCT and quality-scaled quantization of Y, Cb and Cr.
// ----------------------------------------------------------------------------
// A block of 64 sample words is taken in row-major order at one word per
// cycle, while the store is not full, into the sample store. The engine then
// runs a horizontal pass of 512 multiply-accumulate steps, one per cycle on
// three lanes, and frees the store, so the next block can load while it runs
// the vertical pass (another 512 steps) and quantizes the 64 coefficients one
// at a time through the 12-step serial divider. Coefficients leave in
// increasing index through a four-word queue. Quality is written through
// csr_wr_en and csr_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. It resets to 50.
// ----------------------------------------------------------------------------
module dct8x8_quantizer #(
   parameter int COS_FRAC_BITS = dq_pkg::DEF_COS_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dq_pkg::SAMPLE_W-1:0]    req_y_sample,
   input  logic signed [dq_pkg::SAMPLE_W-1:0]    req_cb_sample,
   input  logic signed [dq_pkg::SAMPLE_W-1:0]    req_cr_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dq_pkg::COEF_W-1:0]      rsp_y_coef,
   output logic signed [dq_pkg::COEF_W-1:0]      rsp_cb_coef,
   output logic signed [dq_pkg::COEF_W-1:0]      rsp_cr_coef,
   output logic [dq_pkg::IDX_W-1:0]              rsp_coef_index,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  logic [dq_pkg::QUAL_W-1:0]             csr_wr_data
);

   logic [dq_pkg::QUAL_W-1:0]      quality_ff;
   dq_pkg::dq_front_stat_type      front_stat;
   dq_pkg::dq_rd_req_type          rd_req;
   logic [3*dq_pkg::SAMPLE_W-1:0]  sample_rd;
   logic                           queue_full;
   logic                           res_push;
   dq_pkg::dq_result_type          res;
   dq_pkg::dq_result_type          head;

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_ff <= dq_pkg::DEF_QUALITY;
      end else if (csr_wr_en) begin
         quality_ff <= csr_wr_data;
      end
   end

   dq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_y_sample  (req_y_sample),
      .req_cb_sample (req_cb_sample),
      .req_cr_sample (req_cr_sample),
      .rd_req        (rd_req),
      .stat          (front_stat),
      .sample_rd     (sample_rd)
   );

   dq_engine #(
      .COS_FRAC_BITS (COS_FRAC_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .front_stat (front_stat),
      .sample_rd  (sample_rd),
      .quality    (quality_ff),
      .queue_full (queue_full),
      .rd_req     (rd_req),
      .res_push   (res_push),
      .res        (res)
   );

   dq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_y_coef     = head.y;
   assign rsp_cb_coef    = head.cb;
   assign rsp_cr_coef    = head.cr;
   assign rsp_coef_index = head.idx;
   assign rsp_last       = head.last;

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8x8 DCT quantizer.
// ----------------------------------------------------------------------------
// Two blocks of 64 sample words are pushed through the block at one quality
// setting, picked at random from 0, 1, 100, 127 and the range 2..99. The
// first block carries alternating extremes and the second random samples. A
// scoreboard keeps its own copy of the sample store and computes the exact
// integer DCT, quantization and saturation. Each coefficient word that leaves
// the block is checked field by field. Both sides insert random gaps. The
// receiver holds off long enough for the second block to back up against the
// first, and halfway through the second block the sender waits until all
// results of the first block have drained.
// ----------------------------------------------------------------------------
module tb;

   localparam int FB        = dq_pkg::DEF_COS_FRAC_BITS;
   localparam int LIMIT     = 400000;
   localparam int HOLD_LEN  = 6000;
   localparam int PAT_CHECK = 1;
   localparam int PAT_RAND  = 2;
   localparam int NO_PAUSE  = -1;

   class coef_scoreboard;
      logic [dq_pkg::QUAL_W-1:0] quality;
      int                        smp [3][dq_pkg::BLOCK_ITEMS];
      int                        count;
      int                        errors;
      dq_pkg::dq_result_type     pending [$];

      function new();
         quality = dq_pkg::DEF_QUALITY;
         count   = 0;
         errors  = 0;
      endfunction

      function longint cos_val(int k, int n);
         int m;
         longint sgn;
         sgn = 1;
         if (k == 0) return longint'(dq_pkg::HALF_COS[FB-10][0]);
         m = ((2 * n + 1) * k) % 32;
         if (m > 16) m = 32 - m;
         if (m > 8) begin
            m   = 16 - m;
            sgn = -1;
         end
         return sgn * longint'(dq_pkg::HALF_COS[FB-10][m]);
      endfunction

      // Rounds half away from zero, then saturates to the 11-bit range.
      function logic signed [dq_pkg::COEF_W-1:0] quantize(longint sum, int div);
         longint mag, d, r;
         mag = (sum < 0) ? -sum : sum;
         d   = longint'(div) <<< (2 * FB);
         r   = (2 * mag + d) / (2 * d);
         if (sum < 0) begin
            if (r > dq_pkg::COEF_NEG_MAG) r = dq_pkg::COEF_NEG_MAG;
            return dq_pkg::COEF_W'(-r);
         end
         if (r > dq_pkg::COEF_POS_MAX) r = dq_pkg::COEF_POS_MAX;
         return dq_pkg::COEF_W'(r);
      endfunction

      function void note_sample(logic signed [dq_pkg::SAMPLE_W-1:0] y,
                                logic signed [dq_pkg::SAMPLE_W-1:0] cb,
                                logic signed [dq_pkg::SAMPLE_W-1:0] cr);
         longint row_sum [3][dq_pkg::BLOCK_DIM][dq_pkg::BLOCK_DIM];
         longint acc;
         int q, scale, tab, div;
         dq_pkg::dq_result_type exp_word;
         smp[0][count] = y;
         smp[1][count] = cb;
         smp[2][count] = cr;
         if (count != dq_pkg::BLOCK_ITEMS - 1) begin
            count++;
            return;
         end
         count = 0;
         for (int c = 0; c < 3; c++)
            for (int r = 0; r < dq_pkg::BLOCK_DIM; r++)
               for (int u = 0; u < dq_pkg::BLOCK_DIM; u++) begin
                  acc = 0;
                  for (int x = 0; x < dq_pkg::BLOCK_DIM; x++)
                     acc += longint'(smp[c][r*dq_pkg::BLOCK_DIM+x]) * cos_val(u, x);
                  row_sum[c][r][u] = acc;
               end
         q = int'(quality);
         if (q < 1 || q > 100) q = int'(dq_pkg::DEF_QUALITY);
         scale = (q < 50) ? 5000 / q : 200 - 2 * q;
         for (int v = 0; v < dq_pkg::BLOCK_DIM; v++)
            for (int u = 0; u < dq_pkg::BLOCK_DIM; u++) begin
               logic signed [dq_pkg::COEF_W-1:0] coef [3];
               for (int c = 0; c < 3; c++) begin
                  tab = (c == 0) ? int'(dq_pkg::LUM_TAB[v*dq_pkg::BLOCK_DIM+u])
                                 : int'(dq_pkg::CHR_TAB[v*dq_pkg::BLOCK_DIM+u]);
                  div = (scale * tab + 50) / 100;
                  if (div < 1) div = 1;
                  acc = 0;
                  for (int r = 0; r < dq_pkg::BLOCK_DIM; r++)
                     acc += row_sum[c][r][u] * cos_val(v, r);
                  coef[c] = quantize(acc, div);
               end
               exp_word.y    = coef[0];
               exp_word.cb   = coef[1];
               exp_word.cr   = coef[2];
               exp_word.idx  = dq_pkg::IDX_W'(v * dq_pkg::BLOCK_DIM + u);
               exp_word.last = (v * dq_pkg::BLOCK_DIM + u == dq_pkg::BLOCK_ITEMS - 1);
               pending.push_back(exp_word);
            end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check(dq_pkg::dq_result_type got);
         dq_pkg::dq_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected coefficient word, index %0d", got.idx));
            return;
         end
         want = pending.pop_front();
         if (got.y !== want.y)
            report($sformatf("idx %0d y %0d want %0d", want.idx, got.y, want.y));
         if (got.cb !== want.cb)
            report($sformatf("idx %0d cb %0d want %0d", want.idx, got.cb, want.cb));
         if (got.cr !== want.cr)
            report($sformatf("idx %0d cr %0d want %0d", want.idx, got.cr, want.cr));
         if (got.idx !== want.idx)
            report($sformatf("index %0d want %0d", got.idx, want.idx));
         if (got.last !== want.last)
            report($sformatf("idx %0d last %0b want %0b", want.idx, got.last, want.last));
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [dq_pkg::SAMPLE_W-1:0] req_y_sample = '0;
   logic signed [dq_pkg::SAMPLE_W-1:0] req_cb_sample = '0;
   logic signed [dq_pkg::SAMPLE_W-1:0] req_cr_sample = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [dq_pkg::COEF_W-1:0]   rsp_y_coef;
   logic signed [dq_pkg::COEF_W-1:0]   rsp_cb_coef;
   logic signed [dq_pkg::COEF_W-1:0]   rsp_cr_coef;
   logic [dq_pkg::IDX_W-1:0]           rsp_coef_index;
   logic                               rsp_last;
   logic                               csr_wr_en = 1'b0;
   logic [dq_pkg::QUAL_W-1:0]          csr_wr_data = '0;

   coef_scoreboard sb = new();
   int  cycles = 0;
   int  hold_left = 0;
   bit  hold_req = 0;
   bit  no_idle = 0;

   dct8x8_quantizer u_top (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check('{y: rsp_y_coef, cb: rsp_cb_coef, cr: rsp_cr_coef,
                    idx: rsp_coef_index, last: rsp_last});
   end

   // Receiver: random stalls, and one long hold-off on request.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req  = 0;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (no_idle) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(99) < 3) begin
         hold_left = $urandom_range(10, 60);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < 25);
      end
   end

   function int pick_gap();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Drives one word starting at a falling edge, returns after acceptance.
   task send_word(logic [dq_pkg::SAMPLE_W-1:0] y, logic [dq_pkg::SAMPLE_W-1:0] cb,
                  logic [dq_pkg::SAMPLE_W-1:0] cr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_y_sample  <= y;
      req_cb_sample <= cb;
      req_cr_sample <= cr;
      do @(posedge clock); while (req_stall);
      sb.note_sample(y, cb, cr);
      @(negedge clock);
   endtask

   function logic [dq_pkg::SAMPLE_W-1:0] rand_sample();
      int p;
      p = $urandom_range(9);
      if (p == 0) return 8'h80;
      if (p == 1) return 8'h7f;
      return dq_pkg::SAMPLE_W'($urandom_range(255));
   endfunction

   task drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   // Sends one block; at word pause_at the sender waits for every result.
   task send_block(int pat, int pause_at);
      no_idle = ($urandom_range(3) == 0);
      for (int i = 0; i < dq_pkg::BLOCK_ITEMS; i++) begin
         if (i == pause_at) begin
            req_valid <= 1'b0;
            @(negedge clock);
            drain();
         end
         case (pat)
            PAT_CHECK: begin
               // Alternating extremes drive the highest frequency to its largest magnitude.
               if (((i / dq_pkg::BLOCK_DIM) + (i % dq_pkg::BLOCK_DIM)) % 2 == 1)
                  send_word(8'h80, 8'h7f, 8'h80);
               else
                  send_word(8'h7f, 8'h80, 8'h7f);
            end
            default: send_word(rand_sample(), rand_sample(), rand_sample());
         endcase
      end
      req_valid <= 1'b0;
      @(negedge clock);
      no_idle = 0;
   endtask

   task set_quality(logic [dq_pkg::QUAL_W-1:0] q);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      sb.quality = q;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [dq_pkg::QUAL_W-1:0] q_sel;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      case ($urandom_range(4))
         0:       q_sel = 7'd0;
         1:       q_sel = 7'd1;
         2:       q_sel = 7'd100;
         3:       q_sel = 7'd127;
         default: q_sel = 7'($urandom_range(2, 99));
      endcase
      set_quality(q_sel);
      // The receiver goes quiet while two blocks are offered back to back.
      hold_req = 1;
      send_block(PAT_CHECK, NO_PAUSE);
      send_block(PAT_RAND, dq_pkg::BLOCK_ITEMS / 2);
      drain();

      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
